// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define CHK_RUN(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("check failed while running");

// Checked on every edge, reset included.
`define CHK_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("check failed around reset");

`endif

// ===== rtl/stt_pkg.sv =====
// Package: token kinds, character classes, keyword match and token record.
`default_nettype none
package stt_pkg;

    localparam int KEYWORD_BYTES_DEF = 6;
    localparam int POSITION_BITS_DEF = 16;
    localparam int OFFSET_BITS_DEF   = 32;
    localparam int KW_CMP_BYTES      = 6;

    localparam logic [5:0] K_SPACE     = 6'd0;
    localparam logic [5:0] K_NEWLINE   = 6'd1;
    localparam logic [5:0] K_NAME      = 6'd2;
    localparam logic [5:0] K_NUMBER    = 6'd3;
    localparam logic [5:0] K_STR       = 6'd4;
    localparam logic [5:0] K_UNF_STR   = 6'd5;
    localparam logic [5:0] K_CHSTR     = 6'd6;
    localparam logic [5:0] K_UNF_CHSTR = 6'd7;
    localparam logic [5:0] K_DIVISION  = 6'd8;
    localparam logic [5:0] K_UNF_CMT   = 6'd9;
    localparam logic [5:0] K_SEMI      = 6'd10;
    localparam logic [5:0] K_DOT       = 6'd11;
    localparam logic [5:0] K_COMMA     = 6'd12;
    localparam logic [5:0] K_LPAREN    = 6'd13;
    localparam logic [5:0] K_RPAREN    = 6'd14;
    localparam logic [5:0] K_LBRACE    = 6'd15;
    localparam logic [5:0] K_RBRACE    = 6'd16;
    localparam logic [5:0] K_LBRACKET  = 6'd17;
    localparam logic [5:0] K_RBRACKET  = 6'd18;
    localparam logic [5:0] K_ASSIGN    = 6'd19;
    localparam logic [5:0] K_COLON     = 6'd20;
    localparam logic [5:0] K_CYCLE     = 6'd21;
    localparam logic [5:0] K_CYCLE_REV = 6'd22;
    localparam logic [5:0] K_ILLEGAL   = 6'd23;
    localparam logic [5:0] K_KW_FT     = 6'd24;
    localparam logic [5:0] K_KW_USE    = 6'd25;
    localparam logic [5:0] K_KW_AS     = 6'd26;
    localparam logic [5:0] K_KW_CLASS  = 6'd27;
    localparam logic [5:0] K_KW_MATCH  = 6'd28;
    localparam logic [5:0] K_KW_VOID   = 6'd29;
    localparam logic [5:0] K_KW_BOOL   = 6'd30;
    localparam logic [5:0] K_KW_CHAR   = 6'd31;
    localparam logic [5:0] K_KW_STR    = 6'd32;
    localparam logic [5:0] K_KW_NUM    = 6'd33;
    localparam logic [5:0] K_KW_RETURN = 6'd34;
    localparam logic [5:0] K_MAX       = K_KW_RETURN;

    localparam logic [23:0] UTF8_CYCLE     = 24'hE286BB;
    localparam logic [23:0] UTF8_CYCLE_REV = 24'hE286BA;

    localparam logic [15:0] LENGTH_MAX = 16'hFFFF;

    typedef struct packed {
        logic        last;
        logic [15:0] len;
        logic [31:0] off;
        logic [15:0] col;
        logic [15:0] line;
        logic [5:0]  kind;
    } t_tok;

    typedef struct packed {
        logic [1:0] cnt;
        t_tok       tok1;
        t_tok       tok0;
    } t_push;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A))
            || (b == 8'h5F);
    endfunction

    // Kind of a one-byte punctuation token, or K_ILLEGAL when the byte is none.
    function automatic logic [5:0] single_kind(input logic [7:0] b);
        logic [5:0] k;
        case (b)
            8'h3B:   k = K_SEMI;
            8'h2E:   k = K_DOT;
            8'h2C:   k = K_COMMA;
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h7B:   k = K_LBRACE;
            8'h7D:   k = K_RBRACE;
            8'h5B:   k = K_LBRACKET;
            8'h5D:   k = K_RBRACKET;
            8'h3D:   k = K_ASSIGN;
            default: k = K_ILLEGAL;
        endcase
        return k;
    endfunction

    // Text holds the first name bytes, the first byte in the top bits.
    function automatic logic [5:0] kw_kind(input logic [47:0] t, input logic [15:0] len);
        logic [5:0] k;
        k = K_NAME;
        if (len == 16'd2 && t[47:32] == "ft") k = K_KW_FT;
        if (len == 16'd3 && t[47:24] == "use") k = K_KW_USE;
        if (len == 16'd2 && t[47:32] == "as") k = K_KW_AS;
        if (len == 16'd5 && t[47:8] == "class") k = K_KW_CLASS;
        if (len == 16'd5 && t[47:8] == "match") k = K_KW_MATCH;
        if (len == 16'd4 && t[47:16] == "void") k = K_KW_VOID;
        if (len == 16'd4 && t[47:16] == "bool") k = K_KW_BOOL;
        if (len == 16'd4 && t[47:16] == "char") k = K_KW_CHAR;
        if (len == 16'd3 && t[47:24] == "str") k = K_KW_STR;
        if (len == 16'd3 && t[47:24] == "num") k = K_KW_NUM;
        if (len == 16'd6 && t[47:0] == "return") k = K_KW_RETURN;
        return k;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/stt_core.sv =====
// Scanner core: mode state, open token record and per-beat token decisions.
`default_nettype none
module stt_core
    import stt_pkg::*;
#(
    parameter int KEYWORD_BYTES = KEYWORD_BYTES_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int OFFSET_BITS   = OFFSET_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_final,
    output t_push           o_push
);

    localparam int IW = (KEYWORD_BYTES > 1) ? $clog2(KEYWORD_BYTES) : 1;

    typedef enum logic [14:0] {
        M_IDLE       = 15'b000000000000001,
        M_SPACE      = 15'b000000000000010,
        M_NEWLINE    = 15'b000000000000100,
        M_NAME       = 15'b000000000001000,
        M_NUMBER     = 15'b000000000010000,
        M_DQ         = 15'b000000000100000,
        M_SQ1        = 15'b000000001000000,
        M_SQ_QQ      = 15'b000000010000000,
        M_SQ2        = 15'b000000100000000,
        M_SLASH      = 15'b000001000000000,
        M_LINE_CMT   = 15'b000010000000000,
        M_BLOCK      = 15'b000100000000000,
        M_BLOCK_STAR = 15'b001000000000000,
        M_COLON      = 15'b010000000000000,
        M_UTF8       = 15'b100000000000000
    } t_mode;

    t_mode                    r_mode, n_mode;
    logic [5:0]               r_kind, n_kind;
    logic [POSITION_BITS-1:0] r_line, n_line, r_col, n_col;
    logic [OFFSET_BITS-1:0]   r_off, n_off;
    logic [15:0]              r_len, n_len;
    logic [23:0]              r_gath, n_gath;
    logic [1:0]               r_rem, n_rem;
    logic [POSITION_BITS-1:0] r_line_cnt, n_line_cnt, r_col_cnt, n_col_cnt;
    logic [OFFSET_BITS-1:0]   r_byte_cnt, n_byte_cnt;
    logic [7:0]               r_prefix [KEYWORD_BYTES];

    logic                     taken, ext_flush, pf_we;
    logic [IW-1:0]            pf_idx;
    logic [47:0]              kw_text;
    logic [5:0]               fl_kind, st_kind;
    logic [1:0]               cnt;
    t_tok                     tok0, tok1, cur;
    logic [POSITION_BITS-1:0] col_next;

    function automatic t_tok mk(input logic [5:0] k, input logic [POSITION_BITS-1:0] ln,
                                input logic [POSITION_BITS-1:0] cl,
                                input logic [OFFSET_BITS-1:0] of, input logic [15:0] lg);
        t_tok t;
        t.kind = k;
        t.line = (ln > POSITION_BITS'(16'hFFFF)) ? 16'hFFFF : 16'(ln);
        t.col  = (cl > POSITION_BITS'(16'hFFFF)) ? 16'hFFFF : 16'(cl);
        t.off  = (of > OFFSET_BITS'(32'hFFFFFFFF)) ? 32'hFFFFFFFF : 32'(of);
        t.len  = lg;
        t.last = 1'b0;
        return t;
    endfunction

    function automatic logic [15:0] grow(input logic [15:0] l);
        return (l == LENGTH_MAX) ? LENGTH_MAX : l + 16'd1;
    endfunction

    assign pf_idx   = r_len[IW-1:0];
    assign col_next = (&r_col_cnt) ? r_col_cnt : r_col_cnt + POSITION_BITS'(1);

    always_comb begin
        n_mode     = r_mode;
        n_kind     = r_kind;
        n_line     = r_line;
        n_col      = r_col;
        n_off      = r_off;
        n_len      = r_len;
        n_gath     = r_gath;
        n_rem      = r_rem;
        n_line_cnt = r_line_cnt;
        n_col_cnt  = r_col_cnt;
        n_byte_cnt = r_byte_cnt;
        taken      = 1'b0;
        ext_flush  = 1'b0;
        pf_we      = 1'b0;
        cnt        = 2'd0;
        tok0       = '0;
        tok1       = '0;
        cur        = '0;
        fl_kind    = r_kind;
        st_kind    = K_ILLEGAL;
        kw_text    = '0;

        case (r_mode)
            M_SPACE: begin
                if (is_space(i_byte)) begin
                    n_len = grow(r_len);
                    taken = 1'b1;
                end else begin
                    ext_flush = 1'b1;
                end
            end
            M_NEWLINE: begin
                if (i_byte == 8'h0A) begin
                    n_len = grow(r_len);
                    taken = 1'b1;
                end else begin
                    ext_flush = 1'b1;
                end
            end
            M_NAME: begin
                if (is_alpha(i_byte) || is_digit(i_byte)) begin
                    pf_we = (r_len < 16'(KEYWORD_BYTES));
                    n_len = grow(r_len);
                    taken = 1'b1;
                end else begin
                    ext_flush = 1'b1;
                end
            end
            M_NUMBER: begin
                if (is_digit(i_byte)) begin
                    n_len = grow(r_len);
                    taken = 1'b1;
                end else begin
                    ext_flush = 1'b1;
                end
            end
            M_DQ: begin
                n_len = grow(r_len);
                taken = 1'b1;
                if (i_byte == 8'h22) begin
                    n_kind    = K_STR;
                    ext_flush = 1'b1;
                end
            end
            M_SQ1: begin
                n_len = grow(r_len);
                taken = 1'b1;
                if (i_byte == 8'h27) begin
                    n_kind = K_CHSTR;
                    n_mode = M_SQ_QQ;
                end else begin
                    n_mode = M_SQ2;
                end
            end
            M_SQ_QQ, M_SQ2: begin
                ext_flush = 1'b1;
                if (i_byte == 8'h27) begin
                    n_len  = grow(r_len);
                    n_kind = K_CHSTR;
                    taken  = 1'b1;
                end
            end
            M_SLASH: begin
                if (i_byte == 8'h2F) begin
                    n_mode = M_LINE_CMT;
                    taken  = 1'b1;
                end else if (i_byte == 8'h2A) begin
                    n_len  = grow(r_len);
                    n_kind = K_UNF_CMT;
                    n_mode = M_BLOCK;
                    taken  = 1'b1;
                end else begin
                    ext_flush = 1'b1;
                end
            end
            M_LINE_CMT: begin
                if (i_byte == 8'h0A) begin
                    n_mode = M_IDLE;
                end else begin
                    taken = 1'b1;
                end
            end
            M_BLOCK: begin
                n_len = grow(r_len);
                taken = 1'b1;
                if (i_byte == 8'h2A) n_mode = M_BLOCK_STAR;
            end
            M_BLOCK_STAR: begin
                taken = 1'b1;
                if (i_byte == 8'h2F) begin
                    n_mode = M_IDLE;
                end else begin
                    n_len = grow(r_len);
                    if (i_byte != 8'h2A) n_mode = M_BLOCK;
                end
            end
            M_COLON: begin
                ext_flush = 1'b1;
                if (i_byte == 8'h3A) begin
                    n_len = grow(r_len);
                    taken = 1'b1;
                end
            end
            M_UTF8: begin
                if (i_byte[7:6] == 2'b10) begin
                    n_len  = grow(r_len);
                    taken  = 1'b1;
                    n_gath = {r_gath[15:0], i_byte};
                    n_rem  = (r_rem != 2'd0) ? r_rem - 2'd1 : r_rem;
                    if (n_rem == 2'd0) begin
                        ext_flush = 1'b1;
                        if (n_gath == UTF8_CYCLE) n_kind = K_CYCLE;
                        else if (n_gath == UTF8_CYCLE_REV) n_kind = K_CYCLE_REV;
                        else n_kind = K_ILLEGAL;
                    end
                end else begin
                    ext_flush = 1'b1;
                end
            end
            default: begin
                taken = 1'b0;
            end
        endcase

        for (int i = 0; i < KW_CMP_BYTES; i++) begin
            kw_text[47-8*i -: 8] = (pf_we && pf_idx == IW'(i)) ? i_byte : r_prefix[i];
        end

        if (ext_flush) begin
            fl_kind = (n_mode == M_NAME) ? kw_kind(kw_text, n_len) : n_kind;
            if (n_mode != M_IDLE && n_mode != M_LINE_CMT) begin
                tok0 = mk(fl_kind, n_line, n_col, n_off, n_len);
                cnt  = 2'd1;
            end
            n_mode = M_IDLE;
            n_gath = '0;
            n_rem  = '0;
        end

        if (!taken) begin
            n_line = r_line_cnt;
            n_col  = col_next;
            n_off  = r_byte_cnt;
            n_len  = 16'd1;
            st_kind = single_kind(i_byte);
            if (is_space(i_byte)) begin
                n_kind = K_SPACE;
                n_mode = M_SPACE;
            end else if (i_byte == 8'h0A) begin
                n_kind = K_NEWLINE;
                n_mode = M_NEWLINE;
            end else if (is_alpha(i_byte)) begin
                n_kind = K_NAME;
                n_mode = M_NAME;
            end else if (is_digit(i_byte)) begin
                n_kind = K_NUMBER;
                n_mode = M_NUMBER;
            end else if (i_byte == 8'h22) begin
                n_kind = K_UNF_STR;
                n_mode = M_DQ;
            end else if (i_byte == 8'h27) begin
                n_kind = K_UNF_CHSTR;
                n_mode = M_SQ1;
            end else if (i_byte == 8'h2F) begin
                n_kind = K_DIVISION;
                n_mode = M_SLASH;
            end else if (i_byte == 8'h3A) begin
                n_kind = K_COLON;
                n_mode = M_COLON;
            end else if (st_kind != K_ILLEGAL || i_byte < 8'h80 || i_byte[7:6] == 2'b10
                         || i_byte >= 8'hF8) begin
                n_kind = st_kind;
                n_mode = M_IDLE;
                cur    = mk(st_kind, n_line, n_col, n_off, n_len);
                if (cnt == 2'd0) tok0 = cur;
                else tok1 = cur;
                cnt = cnt + 2'd1;
            end else begin
                n_kind = K_ILLEGAL;
                n_mode = M_UTF8;
                n_gath = {16'd0, i_byte};
                n_rem  = (i_byte >= 8'hF0) ? 2'd3 : (i_byte >= 8'hE0) ? 2'd2 : 2'd1;
            end
        end

        n_byte_cnt = (&r_byte_cnt) ? r_byte_cnt : r_byte_cnt + OFFSET_BITS'(1);
        if (i_byte == 8'h0A) begin
            n_line_cnt = (&r_line_cnt) ? r_line_cnt : r_line_cnt + POSITION_BITS'(1);
            n_col_cnt  = '0;
        end else begin
            n_col_cnt = col_next;
        end

        if (i_final) begin
            fl_kind = (n_mode == M_NAME) ? kw_kind(kw_text, n_len) : n_kind;
            if (n_mode != M_IDLE && n_mode != M_LINE_CMT && cnt != 2'd2) begin
                cur = mk(fl_kind, n_line, n_col, n_off, n_len);
                if (cnt == 2'd0) tok0 = cur;
                else tok1 = cur;
                cnt = cnt + 2'd1;
            end
            n_mode     = M_IDLE;
            n_gath     = '0;
            n_rem      = '0;
            n_line_cnt = POSITION_BITS'(1);
            n_col_cnt  = '0;
            n_byte_cnt = '0;
        end

        if (cnt == 2'd1) tok0.last = 1'b1;
        if (cnt == 2'd2) tok1.last = 1'b1;
    end

    assign o_push.cnt  = i_valid ? cnt : 2'd0;
    assign o_push.tok0 = tok0;
    assign o_push.tok1 = tok1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= M_IDLE;
            r_kind     <= '0;
            r_line     <= '0;
            r_col      <= '0;
            r_off      <= '0;
            r_len      <= '0;
            r_gath     <= '0;
            r_rem      <= '0;
            r_line_cnt <= POSITION_BITS'(1);
            r_col_cnt  <= '0;
            r_byte_cnt <= '0;
        end else if (i_valid) begin
            r_mode     <= n_mode;
            r_kind     <= n_kind;
            r_line     <= n_line;
            r_col      <= n_col;
            r_off      <= n_off;
            r_len      <= n_len;
            r_gath     <= n_gath;
            r_rem      <= n_rem;
            r_line_cnt <= n_line_cnt;
            r_col_cnt  <= n_col_cnt;
            r_byte_cnt <= n_byte_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && pf_we) r_prefix[pf_idx] <= i_byte;
        if (i_valid && !taken && is_alpha(i_byte)) r_prefix[0] <= i_byte;
    end

endmodule
`default_nettype wire

// ===== rtl/stt_outq.sv =====
// Result queue: takes up to two tokens per beat and hands out one per cycle while ready.
`default_nettype none
module stt_outq
    import stt_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    output logic       o_room,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_tok       o_tok
);

    t_tok       r_q [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       pop;

    assign o_valid = (r_cnt != 3'd0);
    assign o_tok   = r_q[r_rp];
    assign o_room  = (r_cnt <= 3'd2);
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + i_push.cnt;
            r_rp  <= r_rp + {1'b0, pop};
            r_cnt <= r_cnt + {1'b0, i_push.cnt} - {2'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) r_q[r_wp] <= i_push.tok0;
        if (i_push.cnt == 2'd2) r_q[r_wp + 2'd1] <= i_push.tok1;
    end

endmodule
`default_nettype wire

// ===== rtl/source_text_tokenizer.sv =====
// Top level of the source text tokenizer: byte stream in, token stream out.
//
//  channel   dir  tdata                                         tlast
//  s_axis    in   [7:0] text_byte                               final_byte
//  m_axis    out  [5:0] kind, [21:6] start_line,                last_of_run
//                 [37:22] start_column, [69:38] start_offset,
//                 [85:70] byte_length
//
// A byte is decided in the cycle it is accepted and its tokens are registered in the queue.
// One byte a cycle is taken while the four-entry result queue has room for two tokens.
// Bytes that yield two tokens fill the queue faster than it drains; input waits for room.
// Reset is synchronous and clears the scanner and the queue; no clearing pass follows.
// A stalled output holds its beat; input is held off while over two tokens are queued.
`default_nettype none
module source_text_tokenizer
    import stt_pkg::*;
#(
    parameter int KEYWORD_BYTES = KEYWORD_BYTES_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int OFFSET_BITS   = OFFSET_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // text_byte
    input  wire logic        s_axis_tlast,   // final_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [87:0]      m_axis_tdata,   // kind, start_line, start_column,
                                             // start_offset, byte_length, zero pad
    output logic             m_axis_tlast    // last_of_run
);

    t_push push;
    t_tok  tok;
    logic  room;

    assign s_axis_tready = room;

    stt_core #(
        .KEYWORD_BYTES(KEYWORD_BYTES),
        .POSITION_BITS(POSITION_BITS),
        .OFFSET_BITS  (OFFSET_BITS)
    ) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid && room),
        .i_byte (s_axis_tdata),
        .i_final(s_axis_tlast),
        .o_push (push)
    );

    stt_outq u_outq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_room (room),
        .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready),
        .o_tok  (tok)
    );

    assign m_axis_tdata = {2'b00, tok.len, tok.off, tok.col, tok.line, tok.kind};
    assign m_axis_tlast = tok.last;

endmodule
`default_nettype wire

// ===== rtl/stt_checker.sv =====
// Port checker for the tokenizer and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"
module stt_checker
    import stt_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [7:0]  s_axis_tdata,
    input wire logic        s_axis_tlast,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [87:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    `CHK_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
    `CHK_RUN(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    `CHK_RUN(a_kind, i_clk, i_rst_n, m_axis_tvalid |-> m_axis_tdata[5:0] <= K_MAX)
    `CHK_RUN(a_len, i_clk, i_rst_n, m_axis_tvalid |-> m_axis_tdata[85:70] != 16'd0 && m_axis_tdata[87:86] == 2'b00)

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (.*);
`default_nettype wire
